FILE: rtl/core/ppi_pkg.sv
`timescale 1ns / 1ps

package ppi_pkg;

    // fixed field widths
    localparam int SPEED_W    = 16;
    localparam int TURN_W     = 16;
    localparam int POSE_W     = 32;
    localparam int HEADING_W  = 16;

    // state widths
    localparam int POSITION_BITS = 32;
    localparam int ANGLE_BITS    = 16;

    // cordic datapath, q2.30 with the angle in 2^32 per turn
    localparam int CORDIC_STEPS = 16;
    localparam int SHIFT_W      = $clog2(CORDIC_STEPS);
    localparam int CW           = 33;
    localparam int ANGLE_FRAC_W = HEADING_W - 2;
    localparam int Z_LSB_W      = 16;
    localparam int CORDIC_GAIN  = 652032874;

    localparam logic signed [CW-1:0] ATAN_TURN [CORDIC_STEPS] = '{
        CW'(536870912), CW'(316933406), CW'(167458907), CW'(85004756),
        CW'(42667331),  CW'(21354465),  CW'(10679838),  CW'(5340245),
        CW'(2670163),   CW'(1335087),   CW'(667544),    CW'(333772),
        CW'(166886),    CW'(83443),     CW'(41721),     CW'(20861)
    };

    // rotation arithmetic
    localparam int TRIG_W      = 17;
    localparam int Q15_SHIFT   = 15;
    localparam int Q15_HALF    = 16384;
    localparam int PROD_W      = TRIG_W + SPEED_W;
    localparam int DSUM_W      = PROD_W + 2;
    localparam int ROUND_SHIFT = 7;
    localparam int ROUND_HALF  = 64;
    localparam int DELTA_W     = DSUM_W - ROUND_SHIFT;
    localparam int SUM_W       = ((POSITION_BITS > DELTA_W) ? POSITION_BITS : DELTA_W) + 1;

    localparam logic signed [SUM_W-1:0] POS_MAX =
        signed'({{(SUM_W - POSITION_BITS + 1){1'b0}}, {(POSITION_BITS - 1){1'b1}}});
    localparam logic signed [SUM_W-1:0] POS_MIN = ~POS_MAX;

    typedef enum logic [1:0] {
        QUAD_I,
        QUAD_II,
        QUAD_III,
        QUAD_IV
    } t_quad;

    typedef struct packed {
        logic signed [CW-1:0]      x;
        logic signed [CW-1:0]      y;
        logic signed [CW-1:0]      z;
        t_quad                     quad;
        logic signed [SPEED_W-1:0] fwd;
        logic signed [SPEED_W-1:0] lat;
        logic [HEADING_W-1:0]      heading;
    } t_cell_data;

    typedef struct packed {
        logic signed [DELTA_W-1:0] dx;
        logic signed [DELTA_W-1:0] dy;
        logic [HEADING_W-1:0]      heading;
    } t_delta;

    // top 16 bits of the angle, zero filled below when the angle is narrower
    function automatic logic [HEADING_W-1:0] angle_to16(input logic [ANGLE_BITS-1:0] a);
        logic [ANGLE_BITS+HEADING_W-1:0] w;
        w = {a, {HEADING_W{1'b0}}};
        return w[ANGLE_BITS+HEADING_W-1 -: HEADING_W];
    endfunction

    // turn rate scaled to the angle width, floor when shifting right
    function automatic logic [ANGLE_BITS-1:0] turn_inc(input logic signed [TURN_W-1:0] t);
        logic [ANGLE_BITS+TURN_W-1:0] w;
        w = {t, {ANGLE_BITS{1'b0}}};
        return w[ANGLE_BITS+TURN_W-1 -: ANGLE_BITS];
    endfunction

endpackage

FILE: rtl/core/ppi_cordic_cell.sv
`timescale 1ns / 1ps

module ppi_cordic_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic [ppi_pkg::SHIFT_W-1:0] i_shift,
    input  logic signed [ppi_pkg::CW-1:0] i_atan,
    input  logic                        i_valid,
    input  ppi_pkg::t_cell_data         i_data,
    output logic                        o_valid,
    output ppi_pkg::t_cell_data         o_data
);
    import ppi_pkg::*;

    logic                 r_valid;
    t_cell_data           r_data;
    t_cell_data           n_data;
    logic signed [CW-1:0] w_xs;
    logic signed [CW-1:0] w_ys;

    assign w_xs = i_data.x >>> i_shift;
    assign w_ys = i_data.y >>> i_shift;

    always_comb begin
        n_data = i_data;
        if (!i_data.z[CW-1]) begin
            n_data.x = i_data.x - w_ys;
            n_data.y = i_data.y + w_xs;
            n_data.z = i_data.z - i_atan;
        end else begin
            n_data.x = i_data.x + w_ys;
            n_data.y = i_data.y - w_xs;
            n_data.z = i_data.z + i_atan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: rtl/core/ppi_rotate.sv
`timescale 1ns / 1ps

module ppi_rotate (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  ppi_pkg::t_cell_data i_data,
    output logic                o_valid,
    output ppi_pkg::t_delta     o_delta
);
    import ppi_pkg::*;

    localparam int RQ_W = CW + 1 - Q15_SHIFT;

    function automatic logic signed [TRIG_W-1:0] sat_q15(input logic signed [RQ_W-1:0] v);
        if (v > signed'(RQ_W'(32767))) begin
            return signed'(TRIG_W'(32767));
        end else if (v < signed'(RQ_W'(-32768))) begin
            return signed'(TRIG_W'(-32768));
        end
        return TRIG_W'(v);
    endfunction

    // trig stage
    logic signed [CW:0]         w_xr;
    logic signed [CW:0]         w_yr;
    logic signed [TRIG_W-1:0]   w_cc;
    logic signed [TRIG_W-1:0]   w_ss;
    logic signed [TRIG_W-1:0]   n_cos;
    logic signed [TRIG_W-1:0]   n_sin;
    logic signed [TRIG_W-1:0]   r_cos;
    logic signed [TRIG_W-1:0]   r_sin;
    logic signed [SPEED_W-1:0]  r_fwd;
    logic signed [SPEED_W-1:0]  r_lat;
    logic [HEADING_W-1:0]       r_head_t;
    logic                       r_vld_t;

    // product stage
    logic signed [PROD_W-1:0]   r_p_fc;
    logic signed [PROD_W-1:0]   r_p_ls;
    logic signed [PROD_W-1:0]   r_p_fs;
    logic signed [PROD_W-1:0]   r_p_lc;
    logic [HEADING_W-1:0]       r_head_p;
    logic                       r_vld_p;

    // sum stage
    logic signed [DSUM_W-1:0]   w_sum_x;
    logic signed [DSUM_W-1:0]   w_sum_y;
    t_delta                     r_delta;
    logic                       r_vld_s;

    assign w_xr = (CW+1)'(i_data.x) + (CW+1)'(Q15_HALF);
    assign w_yr = (CW+1)'(i_data.y) + (CW+1)'(Q15_HALF);
    assign w_cc = sat_q15(w_xr[CW:Q15_SHIFT]);
    assign w_ss = sat_q15(w_yr[CW:Q15_SHIFT]);

    always_comb begin
        case (i_data.quad)
            QUAD_I: begin
                n_cos = w_cc;
                n_sin = w_ss;
            end
            QUAD_II: begin
                n_cos = -w_ss;
                n_sin = w_cc;
            end
            QUAD_III: begin
                n_cos = -w_cc;
                n_sin = -w_ss;
            end
            QUAD_IV: begin
                n_cos = w_ss;
                n_sin = -w_cc;
            end
            default: begin
                n_cos = w_cc;
                n_sin = w_ss;
            end
        endcase
    end

    assign w_sum_x = DSUM_W'(r_p_fc) - DSUM_W'(r_p_ls) + DSUM_W'(ROUND_HALF);
    assign w_sum_y = DSUM_W'(r_p_fs) + DSUM_W'(r_p_lc) + DSUM_W'(ROUND_HALF);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_t <= 1'b0;
            r_vld_p <= 1'b0;
            r_vld_s <= 1'b0;
        end else if (i_en) begin
            r_vld_t <= i_valid;
            r_vld_p <= r_vld_t;
            r_vld_s <= r_vld_p;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cos    <= n_cos;
            r_sin    <= n_sin;
            r_fwd    <= i_data.fwd;
            r_lat    <= i_data.lat;
            r_head_t <= i_data.heading;

            r_p_fc   <= PROD_W'(r_fwd) * PROD_W'(r_cos);
            r_p_ls   <= PROD_W'(r_lat) * PROD_W'(r_sin);
            r_p_fs   <= PROD_W'(r_fwd) * PROD_W'(r_sin);
            r_p_lc   <= PROD_W'(r_lat) * PROD_W'(r_cos);
            r_head_p <= r_head_t;

            r_delta.dx      <= w_sum_x[DSUM_W-1:ROUND_SHIFT];
            r_delta.dy      <= w_sum_y[DSUM_W-1:ROUND_SHIFT];
            r_delta.heading <= r_head_p;
        end
    end

    assign o_valid = r_vld_s;
    assign o_delta = r_delta;

endmodule

FILE: rtl/core/planar_pose_integrator_unit.sv
`timescale 1ns / 1ps
// pipeline: a request's pose appears once it has passed, in order, the
// 16 cordic cells, trig round, multiply, sum and position accumulate registers
// throughput: one request per cycle while o_stall is low; the heading adder and
// the position accumulators each close their loop through their own register
// reset: synchronous active-low clears pose state and all pipeline valids

module planar_pose_integrator_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [ppi_pkg::SPEED_W-1:0]  i_forward_speed,
    input  logic signed [ppi_pkg::SPEED_W-1:0]  i_lateral_speed,
    input  logic signed [ppi_pkg::TURN_W-1:0]   i_turn_rate,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [ppi_pkg::POSE_W-1:0]   o_pose_x,
    output logic signed [ppi_pkg::POSE_W-1:0]   o_pose_y,
    output logic [ppi_pkg::HEADING_W-1:0]       o_pose_heading
);
    import ppi_pkg::*;

    logic                            w_en;
    logic                            w_accept;
    logic [ANGLE_BITS-1:0]           r_heading;
    logic [ANGLE_BITS-1:0]           n_heading;
    logic [HEADING_W-1:0]            w_a16;
    t_cell_data                      w_chain     [CORDIC_STEPS+1];
    logic                            w_chain_vld [CORDIC_STEPS+1];
    logic                            w_rot_valid;
    t_delta                          w_delta;
    logic signed [POSITION_BITS-1:0] r_world_x;
    logic signed [POSITION_BITS-1:0] r_world_y;
    logic signed [SUM_W-1:0]         w_sum_x;
    logic signed [SUM_W-1:0]         w_sum_y;
    logic signed [POSITION_BITS-1:0] n_world_x;
    logic signed [POSITION_BITS-1:0] n_world_y;
    logic [HEADING_W-1:0]            r_out_heading;
    logic                            r_out_valid;

    // whole pipeline holds only while the output register is full and refused
    assign w_en     = !(r_out_valid && i_stall);
    assign o_stall  = !w_en;
    assign w_accept = i_valid && w_en;

    assign n_heading = r_heading + turn_inc(i_turn_rate);
    assign w_a16     = angle_to16(r_heading);

    always_comb begin
        w_chain[0].x       = CW'(CORDIC_GAIN);
        w_chain[0].y       = '0;
        w_chain[0].z       = signed'({{(CW - ANGLE_FRAC_W - Z_LSB_W){1'b0}},
                                      w_a16[ANGLE_FRAC_W-1:0], {Z_LSB_W{1'b0}}});
        w_chain[0].quad    = t_quad'(w_a16[HEADING_W-1:ANGLE_FRAC_W]);
        w_chain[0].fwd     = i_forward_speed;
        w_chain[0].lat     = i_lateral_speed;
        w_chain[0].heading = angle_to16(n_heading);
        w_chain_vld[0]     = i_valid;
    end

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
        ppi_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_shift (SHIFT_W'(g)),
            .i_atan  (ATAN_TURN[g]),
            .i_valid (w_chain_vld[g]),
            .i_data  (w_chain[g]),
            .o_valid (w_chain_vld[g+1]),
            .o_data  (w_chain[g+1])
        );
    end

    ppi_rotate u_rotate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_chain_vld[CORDIC_STEPS]),
        .i_data  (w_chain[CORDIC_STEPS]),
        .o_valid (w_rot_valid),
        .o_delta (w_delta)
    );

    assign w_sum_x = SUM_W'(r_world_x) + SUM_W'(w_delta.dx);
    assign w_sum_y = SUM_W'(r_world_y) + SUM_W'(w_delta.dy);

    always_comb begin
        if (w_sum_x > POS_MAX) begin
            n_world_x = POSITION_BITS'(POS_MAX);
        end else if (w_sum_x < POS_MIN) begin
            n_world_x = POSITION_BITS'(POS_MIN);
        end else begin
            n_world_x = POSITION_BITS'(w_sum_x);
        end
        if (w_sum_y > POS_MAX) begin
            n_world_y = POSITION_BITS'(POS_MAX);
        end else if (w_sum_y < POS_MIN) begin
            n_world_y = POSITION_BITS'(POS_MIN);
        end else begin
            n_world_y = POSITION_BITS'(w_sum_y);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heading   <= '0;
            r_world_x   <= '0;
            r_world_y   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_heading <= n_heading;
            end
            if (w_en) begin
                r_out_valid <= w_rot_valid;
                if (w_rot_valid) begin
                    r_world_x <= n_world_x;
                    r_world_y <= n_world_y;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && w_rot_valid) begin
            r_out_heading <= w_delta.heading;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_pose_x       = POSE_W'(r_world_x);
    assign o_pose_y       = POSE_W'(r_world_y);
    assign o_pose_heading = r_out_heading;

`ifndef SYNTHESIS
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_heading_only_on_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_valid && !o_stall) |=> $stable(r_heading))
        else $error("heading moved without an accepted request");

    a_out_from_pipeline: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(w_rot_valid))
        else $error("result appeared without a rotated request");

    a_pose_held_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> ($stable(r_world_x) && $stable(r_world_y)))
        else $error("pose state changed while the result was refused");
`endif

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import ppi_pkg::*;

    localparam int     RANDOM_REQUESTS = 650;
    localparam int     IDLE_LIMIT      = 2000;
    localparam int     DRAIN_CYCLES    = 40;
    localparam int     HOLD_CYCLES     = 150;
    localparam int     HOLD_AFTER      = 120;
    localparam longint GAIN_Q30        = 652032874;
    localparam longint POS_HI = (longint'(1) <<< (POSITION_BITS - 1)) - 1;
    localparam longint POS_LO = -POS_HI - 1;
    localparam longint ATAN_STEP [CORDIC_STEPS] = '{
        536870912, 316933406, 167458907, 85004756,
        42667331,  21354465,  10679838,  5340245,
        2670163,   1335087,   667544,    333772,
        166886,    83443,     41721,     20861
    };

    typedef struct packed {
        logic signed [POSE_W-1:0] x;
        logic signed [POSE_W-1:0] y;
        logic [HEADING_W-1:0]     heading;
    } t_pose;

    typedef enum {
        SEG_SCATTER,
        SEG_CORNER,
        SEG_CRUISE
    } t_seg_kind;

    class pose_scoreboard;
        longint               pos_x;
        longint               pos_y;
        logic [HEADING_W-1:0] heading;
        t_pose                expected_poses[$];
        int                   errors;
        int                   requests_noted;

        function new();
            pos_x          = 0;
            pos_y          = 0;
            heading        = '0;
            errors         = 0;
            requests_noted = 0;
        endfunction

        function longint round_q15(input longint v);
            longint r;
            r = (v + 16384) >>> 15;
            if (r > 32767) r = 32767;
            if (r < -32768) r = -32768;
            return r;
        endfunction

        function longint clamp_pos(input longint v);
            if (v > POS_HI) return POS_HI;
            if (v < POS_LO) return POS_LO;
            return v;
        endfunction

        // cordic on the low 14 bits, quadrant folded back afterwards
        function void heading_trig(input logic [HEADING_W-1:0] a,
                                   output longint cosv, output longint sinv);
            longint x, y, z, xs, ys, cc, ss;
            x = GAIN_Q30;
            y = 0;
            z = longint'(a[HEADING_W-3:0]) <<< 16;
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0) begin
                    x = x - ys;
                    y = y + xs;
                    z = z - ATAN_STEP[i];
                end else begin
                    x = x + ys;
                    y = y - xs;
                    z = z + ATAN_STEP[i];
                end
            end
            cc = round_q15(x);
            ss = round_q15(y);
            case (t_quad'(a[HEADING_W-1 -: 2]))
                QUAD_I: begin
                    cosv = cc;
                    sinv = ss;
                end
                QUAD_II: begin
                    cosv = -ss;
                    sinv = cc;
                end
                QUAD_III: begin
                    cosv = -cc;
                    sinv = -ss;
                end
                default: begin
                    cosv = ss;
                    sinv = -cc;
                end
            endcase
        endfunction

        function void note_request(input logic signed [SPEED_W-1:0] fwd,
                                   input logic signed [SPEED_W-1:0] lat,
                                   input logic signed [TURN_W-1:0]  turn);
            longint c, s, dx, dy;
            t_pose  p;
            heading_trig(heading, c, s);
            dx = (longint'(fwd) * c - longint'(lat) * s + 64) >>> 7;
            dy = (longint'(fwd) * s + longint'(lat) * c + 64) >>> 7;
            pos_x   = clamp_pos(pos_x + dx);
            pos_y   = clamp_pos(pos_y + dy);
            heading = heading + HEADING_W'(turn);
            p.x       = pos_x[POSE_W-1:0];
            p.y       = pos_y[POSE_W-1:0];
            p.heading = heading;
            expected_poses.push_back(p);
            requests_noted++;
        endfunction

        function void check_pose(input logic signed [POSE_W-1:0] x,
                                 input logic signed [POSE_W-1:0] y,
                                 input logic [HEADING_W-1:0]     h);
            t_pose p;
            if (expected_poses.size() == 0) begin
                $error("pose result with no request pending: x %0d y %0d heading %0d",
                       x, y, h);
                errors++;
                return;
            end
            p = expected_poses.pop_front();
            if (x !== p.x) begin
                $error("pose_x mismatch: expected %0d, got %0d", p.x, x);
                errors++;
            end
            if (y !== p.y) begin
                $error("pose_y mismatch: expected %0d, got %0d", p.y, y);
                errors++;
            end
            if (h !== p.heading) begin
                $error("pose_heading mismatch: expected %0d, got %0d", p.heading, h);
                errors++;
            end
        endfunction
    endclass

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_valid = 1'b0;
    logic                        o_stall;
    logic signed [SPEED_W-1:0]   i_forward_speed = '0;
    logic signed [SPEED_W-1:0]   i_lateral_speed = '0;
    logic signed [TURN_W-1:0]    i_turn_rate = '0;
    logic                        o_valid;
    logic                        i_stall = 1'b0;
    logic signed [POSE_W-1:0]    o_pose_x;
    logic signed [POSE_W-1:0]    o_pose_y;
    logic [HEADING_W-1:0]        o_pose_heading;

    pose_scoreboard sb;
    int             requests_sent = 0;
    int             burst_left = 8;
    int             idle_cycles = 0;
    bit             hold_done = 1'b0;

    planar_pose_integrator_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_forward_speed (i_forward_speed),
        .i_lateral_speed (i_lateral_speed),
        .i_turn_rate     (i_turn_rate),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_pose_x        (o_pose_x),
        .o_pose_y        (o_pose_y),
        .o_pose_heading  (o_pose_heading)
    );

    always #2 i_clk = ~i_clk;

    task automatic send_request(input logic signed [SPEED_W-1:0] fwd,
                                input logic signed [SPEED_W-1:0] lat,
                                input logic signed [TURN_W-1:0]  turn);
        int gap;
        i_valid         <= 1'b1;
        i_forward_speed <= fwd;
        i_lateral_speed <= lat;
        i_turn_rate     <= turn;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_request(fwd, lat, turn);
        requests_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            // now and then a long unbroken burst
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 250)
                                                      : $urandom_range(1, 24);
        end
    endtask

    function automatic logic signed [SPEED_W-1:0] corner_value();
        case ($urandom_range(0, 8))
            0: return 16'sh0000;
            1: return 16'sh0001;
            2: return 16'shFFFF;
            3: return 16'sh7FFF;
            4: return 16'sh8000;
            5: return 16'sh4000;
            6: return 16'shC000;
            7: return 16'sh0100;
            default: return 16'shFF00;
        endcase
    endfunction

    // steer to heading zero, then push hard along the chosen world signs
    task automatic cruise(input int len, input int sx, input int sy, input bit to_limit);
        int  n;
        int  tail;
        bit  at_limit;
        logic signed [SPEED_W-1:0] fwd, lat;
        tail = 15;
        send_request(16'($urandom()), 16'($urandom()), TURN_W'(-sb.heading));
        for (n = 0; n < len; n++) begin
            fwd = (sx > 0) ? SPEED_W'($urandom_range(30000, 32767))
                           : SPEED_W'(-int'($urandom_range(30000, 32768)));
            lat = (sy > 0) ? SPEED_W'($urandom_range(30000, 32767))
                           : SPEED_W'(-int'($urandom_range(30000, 32768)));
            send_request(fwd, lat, TURN_W'(int'($urandom_range(0, 16)) - 8));
            at_limit = (sb.pos_x == ((sx > 0) ? POS_HI : POS_LO)) &&
                       (sb.pos_y == ((sy > 0) ? POS_HI : POS_LO));
            if (to_limit && at_limit) begin
                tail--;
                if (tail == 0) break;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_pose(o_pose_x, o_pose_y, o_pose_heading);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin : stall_pattern
        int mode;
        int span;
        int period;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!hold_done && sb.requests_noted >= HOLD_AFTER) begin
                // long hold so the pipeline backs up into the input
                hold_done = 1'b1;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                mode   = $urandom_range(0, 2);
                span   = $urandom_range(20, 150);
                period = $urandom_range(2, 6);
                for (int c = 0; c < span; c++) begin
                    case (mode)
                        0: i_stall <= 1'b0;
                        1: i_stall <= ($urandom_range(0, 99) < 35);
                        default: i_stall <= ((c % period) == 0);
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    initial begin : main
        t_seg_kind seg;
        int        seg_len;
        int        target;
        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // field extremes and every quadrant, heading wrap both ways
        send_request(16'sh0000, 16'sh0000, 16'sh0000);
        send_request(16'sh7FFF, 16'sh0000, 16'sh0000);
        send_request(16'sh8000, 16'sh0000, 16'sh0000);
        send_request(16'sh0000, 16'sh7FFF, 16'sh0000);
        send_request(16'sh0000, 16'sh8000, 16'sh0000);
        send_request(16'sh7FFF, 16'sh8000, 16'sh4000);
        send_request(16'sh8000, 16'sh7FFF, 16'sh4000);
        send_request(16'sh7FFF, 16'sh7FFF, 16'sh4000);
        send_request(16'shFFFF, 16'shFFFF, 16'sh4000);
        send_request(16'sh0001, 16'sh0001, 16'shFFFF);
        send_request(16'sh8000, 16'sh8000, 16'sh7FFF);
        send_request(16'sh7FFF, 16'sh7FFF, 16'sh8000);
        send_request(16'sh0100, 16'shFF00, 16'sh2000);
        send_request(16'shFF00, 16'sh0100, 16'sh0001);
        send_request(16'sh3039, 16'shCFC7, 16'sh8000);
        send_request(16'sh0000, 16'sh0000, 16'sh1000);

        target = requests_sent + RANDOM_REQUESTS;
        for (int n = 0; n < 40; n++) begin
            send_request(16'($urandom()), 16'($urandom()), 16'($urandom()));
        end
        // drive x to its low limit and y to its high limit
        cruise(330, -1, 1, 1'b1);

        while (requests_sent < target) begin
            seg = t_seg_kind'($urandom_range(0, 2));
            case (seg)
                SEG_SCATTER: begin
                    seg_len = $urandom_range(20, 60);
                    for (int n = 0; n < seg_len; n++) begin
                        send_request(16'($urandom()), 16'($urandom()), 16'($urandom()));
                    end
                end
                SEG_CORNER: begin
                    seg_len = $urandom_range(10, 30);
                    for (int n = 0; n < seg_len; n++) begin
                        send_request(corner_value(), corner_value(), corner_value());
                    end
                end
                default: begin
                    cruise($urandom_range(40, 120), ($urandom_range(0, 1) != 0) ? 1 : -1,
                           ($urandom_range(0, 1) != 0) ? 1 : -1, 1'b0);
                end
            endcase
        end
        i_valid <= 1'b0;

        while (sb.expected_poses.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/ppi_pkg.sv
rtl/core/ppi_cordic_cell.sv
rtl/core/ppi_rotate.sv
rtl/core/planar_pose_integrator_unit.sv
test/tb_top.sv
